@@ hdl/afs_pkg.sv @@
// Shared constants, types and microcode store of the animation frame selector.
package afs_pkg;

	localparam int MAX_FRAMES = 256;
	localparam int SLOT_W     = $clog2(MAX_FRAMES);
	localparam int TOTAL_W    = 9;
	localparam int DUR_W      = 16;
	localparam int ELAPSED_W  = 40;
	localparam int RATE_W     = 16;
	localparam int START_W    = 32;
	localparam int FRAC_W     = 8;
	localparam int CYCLE_W    = DUR_W + SLOT_W;
	localparam int PROD_W     = ELAPSED_W + RATE_W;
	localparam int QUOT_W     = PROD_W - FRAC_W;
	localparam int CNT_W      = 8;

	localparam int MODN_STEPS = START_W;
	localparam int MUL_STEPS  = RATE_W;
	localparam int DIV_STEPS  = QUOT_W;

	localparam logic OPER_LOAD  = 1'b0;
	localparam logic OPER_QUERY = 1'b1;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_MODN_INIT,
		OP_MODN_STEP,
		OP_SET_FRAME,
		OP_SUM_PRIME,
		OP_SUM_STEP,
		OP_MUL_INIT,
		OP_MUL_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_WALK_INIT,
		OP_WALK_PRIME,
		OP_WALK_STEP,
		OP_EMIT
	} uop_t;

	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_QUERY,
		COND_N_ZERO,
		COND_HELD,
		COND_CYC_ZERO,
		COND_MORE_MODN,
		COND_MORE_MUL,
		COND_MORE_DIV,
		COND_MORE_SUM,
		COND_WALK_MORE,
		COND_OUT_BUSY
	} cond_t;

	localparam int UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t UA_IDLE = 4'd0;
	localparam upc_t UA_MODN = 4'd2;
	localparam upc_t UA_SUM  = 4'd5;
	localparam upc_t UA_MUL  = 4'd7;
	localparam upc_t UA_DIV  = 4'd9;
	localparam upc_t UA_WALK = 4'd12;
	localparam upc_t UA_EMIT = 4'd13;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		upc_t  target;
	} uword_t;

	typedef struct packed {
		logic idle;
		uop_t op;
	} ctrl_t;

	typedef struct packed {
		logic query_xfer;
		logic n_zero;
		logic held;
		logic cyc_zero;
		logic more_modn;
		logic more_mul;
		logic more_div;
		logic more_sum;
		logic walk_more;
		logic out_busy;
	} stat_t;

	function automatic uword_t ucode_rom(upc_t addr);
		uword_t w;
		unique case (addr)
			4'd0:    w = '{OP_LATCH,      COND_NO_QUERY,  UA_IDLE};
			4'd1:    w = '{OP_MODN_INIT,  COND_N_ZERO,    UA_EMIT};
			4'd2:    w = '{OP_MODN_STEP,  COND_MORE_MODN, UA_MODN};
			4'd3:    w = '{OP_SET_FRAME,  COND_HELD,      UA_EMIT};
			4'd4:    w = '{OP_SUM_PRIME,  COND_NEVER,     UA_IDLE};
			4'd5:    w = '{OP_SUM_STEP,   COND_MORE_SUM,  UA_SUM};
			4'd6:    w = '{OP_MUL_INIT,   COND_CYC_ZERO,  UA_EMIT};
			4'd7:    w = '{OP_MUL_STEP,   COND_MORE_MUL,  UA_MUL};
			4'd8:    w = '{OP_DIV_INIT,   COND_NEVER,     UA_IDLE};
			4'd9:    w = '{OP_DIV_STEP,   COND_MORE_DIV,  UA_DIV};
			4'd10:   w = '{OP_WALK_INIT,  COND_NEVER,     UA_IDLE};
			4'd11:   w = '{OP_WALK_PRIME, COND_NEVER,     UA_IDLE};
			4'd12:   w = '{OP_WALK_STEP,  COND_WALK_MORE, UA_WALK};
			4'd13:   w = '{OP_EMIT,       COND_OUT_BUSY,  UA_EMIT};
			default: w = '{OP_NOP,        COND_ALWAYS,    UA_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ hdl/animation_frame_selector_unit.sv @@
// Top level of the animation frame selector: duration table, sequencer, datapath.
// Load: written at the transfer edge; the next item may transfer on the following edge.
// Query: for N frames in use, 32 modulo, 16 multiply, 48 divide steps, N sum steps and up to N
//   walk reads (held: ends after modulo; zero cycle length: after sum; no frames: at once), then
//   the result loads; a NOP step then returns to idle for the next item, even while it waits.
// Reset (arst_n low, asynchronous): sequencer idle, no result pending, frame total 0;
//   the duration table is not cleared and holds garbage until loaded.
module animation_frame_selector_unit import afs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TOTAL_W-1:0]   cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [SLOT_W-1:0]    frame_slot,
	input  logic [DUR_W-1:0]     duration_ms,
	input  logic [ELAPSED_W-1:0] elapsed_time,
	input  logic [RATE_W-1:0]    play_rate,
	input  logic                 paused,
	input  logic [START_W-1:0]   start_frame,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SLOT_W-1:0]    shown_frame
);

	ctrl_t             ctrl;
	stat_t             stat;
	logic              ram_we;
	logic [SLOT_W-1:0] rd_addr;
	logic [DUR_W-1:0]  rd_data;

	assign in_ready = ctrl.idle;
	assign ram_we   = in_valid && in_ready && (operation == OPER_LOAD);

	afs_ram #(
		.WIDTH(DUR_W),
		.DEPTH(MAX_FRAMES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (frame_slot),
		.wdata (duration_ms),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	afs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	afs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.operation    (operation),
		.elapsed_time (elapsed_time),
		.play_rate    (play_rate),
		.paused       (paused),
		.start_frame  (start_frame),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.shown_frame  (shown_frame)
	);

endmodule

@@ hdl/afs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module afs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/afs_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module afs_seq import afs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	upc_t   upc_q;
	upc_t   upc_next;
	uword_t uw;
	logic   jump;

	assign uw = ucode_rom(upc_q);

	always_comb begin
		unique case (uw.cond)
			COND_NEVER:     jump = 1'b0;
			COND_ALWAYS:    jump = 1'b1;
			COND_NO_QUERY:  jump = !stat.query_xfer;
			COND_N_ZERO:    jump = stat.n_zero;
			COND_HELD:      jump = stat.held;
			COND_CYC_ZERO:  jump = stat.cyc_zero;
			COND_MORE_MODN: jump = stat.more_modn;
			COND_MORE_MUL:  jump = stat.more_mul;
			COND_MORE_DIV:  jump = stat.more_div;
			COND_MORE_SUM:  jump = stat.more_sum;
			COND_WALK_MORE: jump = stat.walk_more;
			COND_OUT_BUSY:  jump = stat.out_busy;
			default:        jump = 1'b1;
		endcase
	end

	always_comb begin
		upc_next = jump ? uw.target : upc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	always_comb begin
		ctrl.op   = uw.op;
		ctrl.idle = (upc_q == UA_IDLE);
	end

endmodule

@@ hdl/afs_dp.sv @@
// Datapath: query registers, separate add/subtract logic per step, output register.
module afs_dp import afs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_t                ctrl,
	output stat_t                stat,
	input  logic                 cfg_we,
	input  logic [TOTAL_W-1:0]   cfg_wdata,
	input  logic                 in_valid,
	input  logic                 operation,
	input  logic [ELAPSED_W-1:0] elapsed_time,
	input  logic [RATE_W-1:0]    play_rate,
	input  logic                 paused,
	input  logic [START_W-1:0]   start_frame,
	output logic [SLOT_W-1:0]    rd_addr,
	input  logic [DUR_W-1:0]     rd_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SLOT_W-1:0]    shown_frame
);

	logic [TOTAL_W-1:0]   frame_total_q;
	logic [TOTAL_W-1:0]   n_q;
	logic                 hold_q;
	logic [RATE_W-1:0]    rate_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [START_W-1:0]   start_q;
	logic [SLOT_W-1:0]    remn_q;
	logic [SLOT_W-1:0]    res_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [SLOT_W-1:0]    cand_q;
	logic [CYCLE_W-1:0]   cycle_q;
	logic [PROD_W-1:0]    prod_q;
	logic [CYCLE_W-1:0]   rem_q;
	logic                 out_valid_q;
	logic [SLOT_W-1:0]    shown_frame_q;

	logic [TOTAL_W-1:0]   n_cap;
	logic [CNT_W-1:0]     n_last;
	logic [TOTAL_W-1:0]   modn_try;
	logic [SLOT_W-1:0]    modn_next;
	logic [CYCLE_W:0]     div_try;
	logic [CYCLE_W-1:0]   div_next;
	logic [PROD_W-1:0]    mul_next;
	logic                 found;
	logic [SLOT_W-1:0]    idx_inc;
	logic [SLOT_W-1:0]    cand_inc;
	logic                 emit_go;

	function automatic logic [SLOT_W-1:0] wrap_next(logic [SLOT_W-1:0] x,
			logic [TOTAL_W-1:0] n);
		logic [TOTAL_W-1:0] y;
		y = {1'b0, x} + 1'b1;
		return (y == n) ? '0 : y[SLOT_W-1:0];
	endfunction

	always_comb begin
		n_cap     = (frame_total_q > TOTAL_W'(MAX_FRAMES)) ? TOTAL_W'(MAX_FRAMES)
			: frame_total_q;
		n_last    = CNT_W'(n_q - 1'b1);
		modn_try  = {remn_q, start_q[START_W-1]};
		modn_next = (modn_try >= n_q) ? SLOT_W'(modn_try - n_q) : modn_try[SLOT_W-1:0];
		div_try   = {rem_q, prod_q[PROD_W-1]};
		div_next  = (div_try >= {1'b0, cycle_q}) ? CYCLE_W'(div_try - {1'b0, cycle_q})
			: div_try[CYCLE_W-1:0];
		mul_next  = {prod_q[PROD_W-2:0], 1'b0}
			+ (rate_q[RATE_W-1] ? PROD_W'(elapsed_q) : '0);
		found     = rem_q < CYCLE_W'(rd_data);
		idx_inc   = wrap_next(idx_q, n_q);
		cand_inc  = wrap_next(cand_q, n_q);
		emit_go   = !(out_valid_q && !out_ready);
	end

	always_comb begin
		stat.query_xfer = ctrl.idle && in_valid && (operation == OPER_QUERY);
		stat.n_zero     = (n_q == '0);
		stat.held       = hold_q || (n_q == TOTAL_W'(1)) || (rate_q == '0);
		stat.cyc_zero   = (cycle_q == '0);
		stat.more_modn  = (cnt_q != CNT_W'(MODN_STEPS - 1));
		stat.more_mul   = (cnt_q != CNT_W'(MUL_STEPS - 1));
		stat.more_div   = (cnt_q != CNT_W'(DIV_STEPS - 1));
		stat.more_sum   = (cnt_q != n_last);
		stat.walk_more  = !found && (cnt_q != n_last);
		stat.out_busy   = !emit_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_total_q <= cfg_wdata;
			end
			if (ctrl.op == OP_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LATCH: begin
				if (in_valid) begin
					n_q       <= n_cap;
					hold_q    <= paused;
					rate_q    <= play_rate;
					elapsed_q <= elapsed_time;
					start_q   <= start_frame;
				end
			end
			OP_MODN_INIT: begin
				remn_q <= '0;
				res_q  <= '0;
				cnt_q  <= '0;
			end
			OP_MODN_STEP: begin
				remn_q  <= modn_next;
				start_q <= {start_q[START_W-2:0], 1'b0};
				cnt_q   <= cnt_q + 1'b1;
			end
			OP_SET_FRAME: begin
				res_q   <= remn_q;
				cycle_q <= '0;
				idx_q   <= '0;
			end
			OP_SUM_PRIME: begin
				idx_q <= idx_q + 1'b1;
				cnt_q <= '0;
			end
			OP_SUM_STEP: begin
				cycle_q <= cycle_q + CYCLE_W'(rd_data);
				idx_q   <= idx_q + 1'b1;
				cnt_q   <= cnt_q + 1'b1;
			end
			OP_MUL_INIT: begin
				prod_q <= '0;
				cnt_q  <= '0;
			end
			OP_MUL_STEP: begin
				prod_q <= mul_next;
				rate_q <= {rate_q[RATE_W-2:0], 1'b0};
				cnt_q  <= cnt_q + 1'b1;
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q  <= div_next;
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				cnt_q  <= cnt_q + 1'b1;
			end
			OP_WALK_INIT: begin
				idx_q  <= remn_q;
				cand_q <= remn_q;
				cnt_q  <= '0;
			end
			OP_WALK_PRIME: begin
				idx_q <= idx_inc;
			end
			OP_WALK_STEP: begin
				if (found) begin
					res_q <= cand_q;
				end else begin
					rem_q  <= rem_q - CYCLE_W'(rd_data);
					cand_q <= cand_inc;
					idx_q  <= idx_inc;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
			OP_EMIT: begin
				if (emit_go) begin
					shown_frame_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_addr     = idx_q;
	assign out_valid   = out_valid_q;
	assign shown_frame = shown_frame_q;

endmodule

@@ hdl/afs_chk.sv @@
// Port-level checker for the animation frame selector, bound to the top level.
module afs_chk import afs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              operation,
	input logic              out_valid,
	input logic              out_ready,
	input logic [SLOT_W-1:0] shown_frame
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shown_frame))
		else $error("result dropped or changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OPER_QUERY) |=> !in_ready)
		else $error("input ready right after a query transfer");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OPER_LOAD) && !out_valid |=> !out_valid)
		else $error("load produced a result");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready)
		else $error("result appeared while idle");

endmodule

bind animation_frame_selector_unit afs_chk u_afs_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.operation   (operation),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.shown_frame (shown_frame)
);
